// ===== rtl/rpbm_pkg.sv =====
// Package for the RGB pixel blender: blend mode codes, register indexes,
// reset values and the per-channel blend function.
// No dependencies.
package rpbm_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ALPHA = 2'd1;

    localparam logic [3:0] MODE_KEEP    = 4'd0;
    localparam logic [3:0] MODE_REPLACE = 4'd1;
    localparam logic [3:0] MODE_AVG     = 4'd2;
    localparam logic [3:0] MODE_MAX     = 4'd3;
    localparam logic [3:0] MODE_ADD     = 4'd4;
    localparam logic [3:0] MODE_SUB_DS  = 4'd5;
    localparam logic [3:0] MODE_SUB_SD  = 4'd6;
    localparam logic [3:0] MODE_ROWS    = 4'd7;
    localparam logic [3:0] MODE_CHECKER = 4'd8;
    localparam logic [3:0] MODE_XOR     = 4'd9;
    localparam logic [3:0] MODE_ALPHA   = 4'd10;
    localparam logic [3:0] MODE_MUL     = 4'd11;
    localparam logic [3:0] MODE_SLOT    = 4'd12;
    localparam logic [3:0] MODE_MIN     = 4'd13;

    localparam logic [3:0] MODE_RESET  = MODE_REPLACE;
    localparam logic [7:0] ALPHA_RESET = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // floor(n / 255) for n up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] blend_channel(
        input logic [7:0] d,
        input logic [7:0] s,
        input logic [3:0] mode,
        input logic [7:0] alpha,
        input logic       even_row,
        input logic       even_cell
    );
        logic [8:0]  sum;
        logic [15:0] mix;
        logic [15:0] prod;
        logic [7:0]  r;
        sum  = {1'b0, d} + {1'b0, s};
        mix  = ({8'd0, s} * {8'd0, alpha}) + ({8'd0, d} * {8'd0, 8'd255 - alpha});
        prod = {8'd0, d} * {8'd0, s};
        unique case (mode)
            MODE_KEEP:    r = d;
            MODE_AVG:     r = sum[8:1];
            MODE_MAX:     r = (d > s) ? d : s;
            MODE_ADD:     r = sum[8] ? 8'hFF : sum[7:0];
            MODE_SUB_DS:  r = (d > s) ? d - s : 8'd0;
            MODE_SUB_SD:  r = (s > d) ? s - d : 8'd0;
            MODE_ROWS:    r = even_row ? s : d;
            MODE_CHECKER: r = even_cell ? s : d;
            MODE_XOR:     r = d ^ s;
            MODE_ALPHA:   r = div255(mix);
            MODE_MUL:     r = div255(prod);
            MODE_MIN:     r = (d < s) ? d : s;
            // replace, buffer slot and unknown codes
            default:      r = s;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rpbm_pix_in_if.sv =====
// Input pixel channel: destination and source RGB888 plus coordinates.
// Depends on rpbm_pkg for the default coordinate width.
interface rpbm_pix_in_if import rpbm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             dest_red;
    logic [7:0]             dest_green;
    logic [7:0]             dest_blue;
    logic [7:0]             src_red;
    logic [7:0]             src_green;
    logic [7:0]             src_blue;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;

    modport source (
        output valid, dest_red, dest_green, dest_blue,
        output src_red, src_green, src_blue, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, dest_red, dest_green, dest_blue,
        input  src_red, src_green, src_blue, pixel_x, pixel_y,
        output ready
    );
endinterface

// ===== rtl/rpbm_pix_out_if.sv =====
// Output pixel channel: blended RGB888.
// No dependencies.
interface rpbm_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

// ===== rtl/rgb_pixel_blend_modes.sv =====
// Channel   Dir  Payload                                   Handshake
// i_pix     in   dest RGB888, src RGB888, pixel_x, pixel_y  valid/ready
// o_pix     out  out RGB888                                valid/ready
// i_cfg_*   in   register index, 8-bit data                write enable only
//
// Two register stages: input register, then blend logic into the result
// register. Throughput is one pixel per cycle while the output is not stalled.
// A stalled output holds its result; the input stage still takes a pixel while
// it is empty. Synchronous active-low reset clears valids and sets the config registers
// (mode = replace, alpha = 128).
// Depends on rpbm_pkg, rpbm_pix_in_if, rpbm_pix_out_if.
module rgb_pixel_blend_modes import rpbm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    rpbm_pix_in_if.sink            i_pix,
    rpbm_pix_out_if.source         o_pix
);

    logic [3:0] r_mode;
    logic [7:0] r_alpha;

    logic       r_s1_valid;
    t_rgb       r_s1_dst;
    t_rgb       r_s1_src;
    logic       r_s1_even_row;
    logic       r_s1_even_cell;

    logic       r_out_valid;
    t_rgb       r_out;
    t_rgb       n_out;

    logic       s1_adv;
    logic       in_ready;
    logic       in_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RESET;
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_MODE) begin
                r_mode <= i_cfg_data[3:0];
            end else if (i_cfg_index == CFG_IDX_ALPHA) begin
                r_alpha <= i_cfg_data[7:0];
            end
        end
    end

    assign s1_adv      = !r_out_valid || o_pix.ready;
    assign in_ready    = !r_s1_valid || s1_adv;
    assign in_xfer     = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_dst       <= '{red: i_pix.dest_red, green: i_pix.dest_green,
                                blue: i_pix.dest_blue};
            r_s1_src       <= '{red: i_pix.src_red, green: i_pix.src_green,
                                blue: i_pix.src_blue};
            // only the coordinate LSBs matter
            r_s1_even_row  <= ~i_pix.pixel_y[0];
            r_s1_even_cell <= ~(i_pix.pixel_x[0] ^ i_pix.pixel_y[0]);
        end
    end

    always_comb begin
        n_out.red   = blend_channel(r_s1_dst.red, r_s1_src.red, r_mode, r_alpha,
                                    r_s1_even_row, r_s1_even_cell);
        n_out.green = blend_channel(r_s1_dst.green, r_s1_src.green, r_mode, r_alpha,
                                    r_s1_even_row, r_s1_even_cell);
        n_out.blue  = blend_channel(r_s1_dst.blue, r_s1_src.blue, r_mode, r_alpha,
                                    r_s1_even_row, r_s1_even_cell);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_red   = r_out.red;
    assign o_pix.out_green = r_out.green;
    assign o_pix.out_blue  = r_out.blue;

endmodule

// ===== rtl/rpbm_checker.sv =====
// Port-level checks for the RGB pixel blender, bound to the top level.
// Depends on rgb_pixel_blend_modes and its channel interfaces.
module rpbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    // a taken output frees the input side in the same cycle
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is taken");

    // an accepted pixel shows up at the output when the output was open
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid)
        else $error("accepted pixel did not reach the output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_red) && $stable(i_out_green)
             && $stable(i_out_blue)))
        else $error("stalled result changed");

endmodule

bind rgb_pixel_blend_modes rpbm_checker u_rpbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red),
    .i_out_green (o_pix.out_green),
    .i_out_blue  (o_pix.out_blue)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rgb_pixel_blend_modes: directed and random pixels
// under every blend mode, with random stalls on both channels.
// Depends on rpbm_pkg, rpbm_pix_in_if, rpbm_pix_out_if and the blender RTL.
module testbench;
    import rpbm_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int STALL_LIMIT = 500;
    localparam int RANDOM_PIXELS = 600;
    localparam int QUIET_AFTER = 520;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam logic [7:0] ALPHA_AT_RESET = 8'd128;

    typedef struct packed {
        t_rgb          dest;
        t_rgb          src;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } t_blend_px;

    class blend_scoreboard;
        logic [3:0] mode = MODE_REPLACE;
        logic [7:0] alpha = ALPHA_AT_RESET;
        t_rgb       expected_q[$];
        int         taken;
        int         delivered;
        int         errors;

        function logic [7:0] blend_value(logic [7:0] d, logic [7:0] s,
                                         bit row_even, bit cell_even);
            int unsigned dv;
            int unsigned sv;
            int unsigned av;
            int unsigned r;
            dv = d;
            sv = s;
            av = alpha;
            case (mode)
                MODE_KEEP:    r = dv;
                MODE_AVG:     r = (dv + sv) / 2;
                MODE_MAX:     r = (dv > sv) ? dv : sv;
                MODE_ADD:     r = (dv + sv > 255) ? 255 : dv + sv;
                MODE_SUB_DS:  r = (dv > sv) ? dv - sv : 0;
                MODE_SUB_SD:  r = (sv > dv) ? sv - dv : 0;
                MODE_ROWS:    r = row_even ? sv : dv;
                MODE_CHECKER: r = cell_even ? sv : dv;
                MODE_XOR:     r = dv ^ sv;
                MODE_ALPHA:   r = (sv * av + dv * (255 - av)) / 255;
                MODE_MUL:     r = (dv * sv) / 255;
                MODE_MIN:     r = (dv < sv) ? dv : sv;
                default:      r = sv;  // replace, buffer slot, unknown codes
            endcase
            return r[7:0];
        endfunction

        function void note_pixel(t_blend_px p);
            t_rgb e;
            bit   row_even;
            bit   cell_even;
            row_even  = !p.y[0];
            cell_even = !(p.x[0] ^ p.y[0]);
            e.red   = blend_value(p.dest.red, p.src.red, row_even, cell_even);
            e.green = blend_value(p.dest.green, p.src.green, row_even, cell_even);
            e.blue  = blend_value(p.dest.blue, p.src.blue, row_even, cell_even);
            expected_q.push_back(e);
            taken++;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_pixel(t_rgb got);
            t_rgb e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("pixel %h with none outstanding", got));
                return;
            end
            e = expected_q.pop_front();
            for (int c = 0; c < 3; c++) begin
                if (got[8*(2-c) +: 8] !== e[8*(2-c) +: 8]) begin
                    report_mismatch($sformatf("pixel %0d %s (mode %0d): got %0d, want %0d",
                        delivered, c == 0 ? "red" : c == 1 ? "green" : "blue",
                        mode, got[8*(2-c) +: 8], e[8*(2-c) +: 8]));
                end
            end
            delivered++;
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    bit                     quiet;
    int                     stall_cycles;
    int                     settings;

    blend_scoreboard sb = new();

    rpbm_pix_in_if #(.COORD_WIDTH(CW)) pix_in ();
    rpbm_pix_out_if pix_out ();

    rgb_pixel_blend_modes dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_in.sink),
        .o_pix       (pix_out.source)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && pix_in.valid && pix_in.ready) begin
            sb.note_pixel({pix_in.dest_red, pix_in.dest_green, pix_in.dest_blue,
                           pix_in.src_red, pix_in.src_green, pix_in.src_blue,
                           pix_in.pixel_x, pix_in.pixel_y});
        end
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            sb.check_pixel({pix_out.out_red, pix_out.out_green, pix_out.out_blue});
        end
    end

    // cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", stall_cycles);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // output backpressure in random bursts
    initial begin
        pix_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            pix_out.ready <= 1'b1;
        end
    end

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_blend_px random_pixel();
        t_blend_px p;
        p.dest = {random_channel(), random_channel(), random_channel()};
        p.src  = {random_channel(), random_channel(), random_channel()};
        p.x    = CW'($urandom_range(0, (1 << CW) - 1));
        p.y    = CW'($urandom_range(0, (1 << CW) - 1));
        return p;
    endfunction

    // leaves the enable high; cfg_close drops it
    task cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_IDX_MODE) begin
            sb.mode = data[3:0];
        end else if (idx == CFG_IDX_ALPHA) begin
            sb.alpha = data;
        end
        @(negedge i_clk);
    endtask

    task cfg_close();
        i_cfg_we <= 1'b0;
    endtask

    task configure(input logic [3:0] mode, input logic [7:0] alpha);
        // upper bits of the mode write must be ignored
        cfg_write(CFG_IDX_MODE, {4'($urandom_range(0, 15)), mode});
        cfg_write(CFG_IDX_ALPHA, alpha);
        cfg_close();
        settings++;
    endtask

    task send_pixel(input t_blend_px p, input bit allow_gap);
        pix_in.valid      <= 1'b1;
        pix_in.dest_red   <= p.dest.red;
        pix_in.dest_green <= p.dest.green;
        pix_in.dest_blue  <= p.dest.blue;
        pix_in.src_red    <= p.src.red;
        pix_in.src_green  <= p.src.green;
        pix_in.src_blue   <= p.src.blue;
        pix_in.pixel_x    <= p.x;
        pix_in.pixel_y    <= p.y;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task stop_sender();
        pix_in.valid <= 1'b0;
    endtask

    // all results in, pipeline empty
    task wait_idle();
        do @(negedge i_clk); while (sb.expected_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task run_directed(input logic [3:0] mode, input logic [7:0] alpha, input t_blend_px p);
        wait_idle();
        configure(mode, alpha);
        send_pixel(p, 1'b0);
        stop_sender();
    endtask

    initial begin
        t_blend_px  px_a;
        t_blend_px  px_b;
        logic [3:0] mode;
        logic [7:0] alpha;
        int         sent;
        int         phase;
        int         n;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_IDX_MODE;
        i_cfg_data        = '0;
        pix_in.valid      = 1'b0;
        pix_in.dest_red   = '0;
        pix_in.dest_green = '0;
        pix_in.dest_blue  = '0;
        pix_in.src_red    = '0;
        pix_in.src_green  = '0;
        pix_in.src_blue   = '0;
        pix_in.pixel_x    = '0;
        pix_in.pixel_y    = '0;
        quiet             = 1'b0;

        // odd row, even cell, full-scale coordinates
        px_a = {8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, CW'('1), CW'('1)};
        // even row, odd cell
        px_b = {8'd0, 8'd0, 8'd200, 8'd255, 8'd0, 8'd100, CW'(1), CW'(0)};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register reset values: replace, alpha 128
        send_pixel(px_a, 1'b0);
        stop_sender();

        for (int m = 0; m < 16; m++) begin
            run_directed(4'(m), (4'(m) == MODE_ALPHA) ? 8'd0 : 8'd128, px_a);
        end
        run_directed(MODE_ROWS, 8'd128, px_b);
        run_directed(MODE_CHECKER, 8'd128, px_b);
        run_directed(MODE_ALPHA, 8'd255, px_b);
        run_directed(MODE_MUL, 8'd0, px_b);

        // writes to unused indexes must not disturb the registers
        wait_idle();
        cfg_write(CFG_IDX_MODE, {4'd0, MODE_SUB_DS});
        cfg_write(CFG_IDX_ALPHA, 8'd77);
        cfg_write(CFG_IDX_SPARE_A, 8'($urandom_range(0, 255)));
        cfg_write(CFG_IDX_SPARE_B, 8'($urandom_range(0, 255)));
        cfg_close();
        settings++;
        send_pixel(px_b, 1'b0);
        stop_sender();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            quiet = (sent >= QUIET_AFTER);
            n     = $urandom_range(15, 50);
            mode  = (phase % 4 == 0) ? MODE_ALPHA : 4'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0:       alpha = 8'd0;
                1:       alpha = 8'd255;
                default: alpha = 8'($urandom_range(0, 255));
            endcase
            wait_idle();
            configure(mode, alpha);
            for (int i = 0; i < n; i++) begin
                if (phase == 2 && i == n / 2) begin
                    // hold the input until the pipeline has drained
                    stop_sender();
                    do @(negedge i_clk); while (sb.expected_q.size() != 0);
                end
                send_pixel(random_pixel(), 1'b1);
                sent++;
            end
            stop_sender();
            phase++;
        end

        wait_idle();
        repeat (5) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d pixels never came out", sb.expected_q.size()));
        end
        $display("Blended %0d pixels (%0d checked) across %0d register settings,",
                 sb.taken, sb.delivered, settings);
        $display("all mode codes, alpha extremes and both coordinate parities.");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpbm_pkg.sv
rtl/rpbm_pix_in_if.sv
rtl/rpbm_pix_out_if.sv
rtl/rgb_pixel_blend_modes.sv
rtl/rpbm_checker.sv
bench/testbench.sv
